// ===== rtl/core/edc_pkg.sv =====
// edc_pkg: shared constants, reciprocals and payload types for the calendar converter
`timescale 1ns / 1ps
`default_nettype none

package edc_pkg;

  // Register stages from input to result, both datapaths together
  localparam int NUM_STAGES = 13;

  // 44 eras of seconds, enough to lift any 40-bit input above zero.
  // An era is a multiple of seven days, so weekday and era phase are kept.
  localparam logic [40:0] SEC_OFFSET  = 41'd555402355200;
  localparam logic [23:0] EPOCH_SHIFT = 24'd719468;
  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
  localparam logic [17:0] LAST_DOE    = 18'd146096;
  // year - 1900 = 400 * (era - 44) + yoe + jan_feb - 1900
  localparam logic [15:0] YEAR_BIAS   = 16'd19500;

  // 86400 = 128 * 675; the odd part goes through a reciprocal
  localparam logic [10:0] SECS_ODD    = 11'd675;

  // Floor reciprocal for the day split, one correction step follows
  localparam logic [31:0] RCP_675   = 32'((64'd1 << 41) / 64'd675);
  // Ceiling reciprocals; each shift is wide enough to be exact over its range
  localparam logic [24:0] RCP_ERA   = 25'(((64'd1 << 42) + 64'd146096) / 64'd146097);
  localparam logic [18:0] RCP_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] RCP_36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] RCP_365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [9:0]  RCP_100   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [11:0] RCP_153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [17:0] RCP_3600  = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] RCP_60    = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam logic [24:0] RCP_7     = 25'(((64'd1 << 27) + 64'd6) / 64'd7);

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } tod_t;

  typedef struct packed {
    logic signed [15:0] years_since_1900;
    logic [3:0]         month_index;
    logic [4:0]         day_of_month;
    logic [8:0]         day_in_year;
  } cal_t;

  // First day of each month in a March-based year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/edc_if.sv =====
// edc_if: valid/ready channel interfaces for input seconds and calendar results
`timescale 1ns / 1ps
`default_nettype none

interface edc_in_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface edc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] years_since_1900;
  logic [3:0]         month_index;
  logic [4:0]         day_of_month;
  logic [4:0]         hour_of_day;
  logic [5:0]         minute_of_hour;
  logic [5:0]         second_of_minute;
  logic [2:0]         weekday;
  logic [8:0]         day_in_year;

  modport source (output valid, output years_since_1900, output month_index,
                  output day_of_month, output hour_of_day, output minute_of_hour,
                  output second_of_minute, output weekday, output day_in_year,
                  input ready);
  modport sink   (input valid, input years_since_1900, input month_index,
                  input day_of_month, input hour_of_day, input minute_of_hour,
                  input second_of_minute, input weekday, input day_in_year,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/epoch_seconds_to_calendar.sv =====
// Path: each accepted input beat is registered through stages 0 to 12 into its result beat.
// Throughput: one beat per cycle while the receiver does not stall; the 13 register stages each hold one item.
// Backpressure: a stage loads whenever the sink is ready or it or a later stage is empty, so bubbles close up.
// Reset: synchronous, active low; clears only the stage valid bits, payload is not reset.
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_calendar (
  input  logic       clk,
  input  logic       rst_n,
  edc_in_if.sink     in_ch,
  edc_out_if.source  out_ch
);
  import edc_pkg::*;

  logic [NUM_STAGES-1:0] stage_ld;

  // Handshake control: valid bits ride alongside the data stages
  edc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stage_ld  (stage_ld)
  );

  // ---------------------------------------------------------------------
  // Day split. The input is lifted by 44 whole eras of seconds so every
  // value is non-negative and the floor split becomes plain unsigned math.
  // 86400 = 128 * 675: the low 7 bits pass straight into the second of day,
  // the rest is divided by 675 with a reciprocal estimate that is at most
  // one short, fixed in the following stage.
  // ---------------------------------------------------------------------
  logic [40:0] u_r;                 // stage 0: lifted seconds
  logic [63:0] q_prod;
  logic [23:0] qe_r;                // stage 1: quotient estimate
  logic [10:0] vlo_r;
  logic [6:0]  slo_r;
  logic [10:0] qe_mul;
  logic [10:0] rem_est;
  logic        rem_fix;
  logic [9:0]  rem_odd;
  logic [23:0] days_r;              // stage 2: lifted day number
  logic [16:0] sod_r;               // stage 2: second of day

  assign q_prod  = 64'(u_r[40:9]) * 64'(RCP_675);
  // The true remainder is below 2 * 675, so 11 bits of the product are enough
  assign qe_mul  = 11'(qe_r[10:0] * SECS_ODD);
  assign rem_est = vlo_r - qe_mul;
  assign rem_fix = (rem_est >= SECS_ODD);
  assign rem_odd = rem_fix ? 10'(rem_est - SECS_ODD) : rem_est[9:0];

  always_ff @(posedge clk) begin
    if (stage_ld[0]) begin
      u_r <= 41'({in_ch.epoch_seconds[39], in_ch.epoch_seconds}) + SEC_OFFSET;
    end
    if (stage_ld[1]) begin
      qe_r  <= q_prod[62:39];
      vlo_r <= u_r[17:7];
      slo_r <= u_r[6:0];
    end
    if (stage_ld[2]) begin
      days_r <= qe_r + 24'(rem_fix);
      sod_r  <= {rem_odd, slo_r};
    end
  end

  // ---------------------------------------------------------------------
  // Time of day and weekday. The era offset is a multiple of a week, so
  // the weekday comes from the lifted day number directly (day 0 of the
  // epoch is a Thursday, hence the +4). Only the low 3 bits of n - 7q are
  // needed, and -7 is +1 modulo 8.
  // ---------------------------------------------------------------------
  logic [34:0] hr_prod;
  logic [4:0]  hr3_r;
  logic [16:0] sod3_r;
  logic [23:0] n7_r;
  logic [48:0] wd_prod;
  logic [11:0] rem4_r;              // seconds within the hour
  logic [4:0]  hr4_r;
  logic [2:0]  wd4_r;
  logic [24:0] mn_prod;
  logic [11:0] rem5_r;
  logic [5:0]  mn5_r;
  logic [4:0]  hr5_r;
  logic [2:0]  wd5_r;
  tod_t        tod6_nxt;
  tod_t        tod_r [6:NUM_STAGES-1];

  assign hr_prod = 35'(sod_r) * 35'(RCP_3600);
  assign wd_prod = 49'(n7_r) * 49'(RCP_7);
  assign mn_prod = 25'(rem4_r) * 25'(RCP_60);

  always_comb begin
    tod6_nxt.hour    = hr5_r;
    tod6_nxt.minute  = mn5_r;
    tod6_nxt.second  = 6'(rem5_r - 12'(12'(mn5_r) * 12'd60));
    tod6_nxt.weekday = wd5_r;
  end

  always_ff @(posedge clk) begin
    if (stage_ld[3]) begin
      hr3_r  <= hr_prod[33:29];
      sod3_r <= sod_r;
      n7_r   <= days_r + 24'd4;
    end
    if (stage_ld[4]) begin
      rem4_r <= 12'(sod3_r - 17'(17'(hr3_r) * 17'd3600));
      hr4_r  <= hr3_r;
      wd4_r  <= n7_r[2:0] + wd_prod[29:27];
    end
    if (stage_ld[5]) begin
      rem5_r <= rem4_r;
      mn5_r  <= mn_prod[23:18];
      hr5_r  <= hr4_r;
      wd5_r  <= wd4_r;
    end
    if (stage_ld[6]) begin
      tod_r[6] <= tod6_nxt;
    end
  end

  // Delay line so the time fields meet the date at the last stage
  genvar d;
  generate
    for (d = 7; d < NUM_STAGES; d++) begin : g_tod_dly
      always_ff @(posedge clk) begin
        if (stage_ld[d]) begin
          tod_r[d] <= tod_r[d-1];
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------------
  // Calendar date from the lifted day number, stages 3 to 12
  // ---------------------------------------------------------------------
  cal_t cal;

  edc_civil u_civil (
    .clk      (clk),
    .stage_ld (stage_ld),
    .days_i   (days_r),
    .cal_o    (cal)
  );

  // Result beat: both datapaths end in the same output register stage
  assign out_ch.years_since_1900 = cal.years_since_1900;
  assign out_ch.month_index      = cal.month_index;
  assign out_ch.day_of_month     = cal.day_of_month;
  assign out_ch.day_in_year      = cal.day_in_year;
  assign out_ch.hour_of_day      = tod_r[NUM_STAGES-1].hour;
  assign out_ch.minute_of_hour   = tod_r[NUM_STAGES-1].minute;
  assign out_ch.second_of_minute = tod_r[NUM_STAGES-1].second;
  assign out_ch.weekday          = tod_r[NUM_STAGES-1].weekday;

endmodule

`default_nettype wire

// ===== rtl/core/edc_pipe_ctrl.sv =====
// edc_pipe_ctrl: per-stage valid bits and load enables with bubble collapsing
`timescale 1ns / 1ps
`default_nettype none

module edc_pipe_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [edc_pkg::NUM_STAGES-1:0]  stage_ld
);
  import edc_pkg::*;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] rdy;

  // A stage may load when the sink takes a beat or any stage at or after it is empty
  genvar k;
  generate
    for (k = 0; k < NUM_STAGES; k++) begin : g_stage
      assign rdy[k] = out_ready || !(&vld_r[NUM_STAGES-1:k]);
      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_r[k] <= 1'b0;
          end else if (rdy[k]) begin
            vld_r[k] <= in_valid;
          end
        end
      end else begin : g_rest
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_r[k] <= 1'b0;
          end else if (rdy[k]) begin
            vld_r[k] <= vld_r[k-1];
          end
        end
      end
    end
  endgenerate

  assign stage_ld  = rdy;
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NUM_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/edc_civil.sv =====
// edc_civil: pipelined day number to year, month, day and day of year
`timescale 1ns / 1ps
`default_nettype none

module edc_civil (
  input  logic                            clk,
  input  logic [edc_pkg::NUM_STAGES-1:0]  stage_ld,
  input  logic [23:0]                     days_i,   // day number plus 44 eras
  output edc_pkg::cal_t                   cal_o
);
  import edc_pkg::*;

  // stage 3: shift to a March-based day count
  logic [23:0] z_r;
  // stage 4: era
  logic [48:0] era_prod;
  logic [6:0]  era4_r;
  logic [17:0] z4_r;
  // stage 5: day of era
  logic [17:0] doe5_r;
  logic [6:0]  era5_r;
  // stage 6: leap corrections
  logic [36:0] a_prod;
  logic [36:0] b_prod;
  logic [6:0]  a6_r;
  logic [2:0]  b6_r;
  logic        c6_r;
  logic [17:0] doe6_r;
  logic [6:0]  era6_r;
  // stage 7
  logic [17:0] t7_r;
  logic [17:0] doe7_r;
  logic [6:0]  era7_r;
  // stage 8: year of era
  logic [36:0] yoe_prod;
  logic [8:0]  yoe8_r;
  logic [17:0] doe8_r;
  logic [6:0]  era8_r;
  // stage 9
  logic [18:0] c100_prod;
  logic [1:0]  y100_9_r;
  logic [17:0] base9_r;
  logic [8:0]  yoe9_r;
  logic [17:0] doe9_r;
  logic [6:0]  era9_r;
  // stage 10: day of year, March based
  logic [8:0]  doy10_r;
  logic        leap10_r;
  logic [8:0]  yoe10_r;
  logic [6:0]  era10_r;
  logic [8:0]  ymod100;
  // stage 11: month
  logic [10:0] mp_num;
  logic [22:0] mp_prod;
  logic [3:0]  mp11_r;
  logic [8:0]  doy11_r;
  logic        leap11_r;
  logic [8:0]  yoe11_r;
  logic [6:0]  era11_r;
  // stage 12: results
  cal_t        cal_nxt;
  cal_t        cal_r;
  logic        jan_feb;

  assign era_prod  = 49'(z_r) * 49'(RCP_ERA);
  assign a_prod    = 37'(doe5_r) * 37'(RCP_1460);
  assign b_prod    = 37'(doe5_r) * 37'(RCP_36524);
  assign yoe_prod  = 37'(t7_r) * 37'(RCP_365);
  assign c100_prod = 19'(yoe8_r) * 19'(RCP_100);
  assign ymod100   = yoe9_r - 9'(9'(y100_9_r) * 9'd100);
  assign mp_num    = 11'(11'(doy10_r) * 11'd5 + 11'd2);
  assign mp_prod   = 23'(mp_num) * 23'(RCP_153);
  assign jan_feb   = (mp11_r >= 4'd10);

  always_comb begin
    cal_nxt.years_since_1900 = 16'(16'(era11_r) * 16'd400 + 16'(yoe11_r)
                                   + 16'(jan_feb) - YEAR_BIAS);
    cal_nxt.month_index      = jan_feb ? 4'(mp11_r - 4'd10) : 4'(mp11_r + 4'd2);
    cal_nxt.day_of_month     = 5'(doy11_r - month_start(mp11_r) + 9'd1);
    // March onward follows Jan and Feb of the same year; Jan/Feb trail March by 306
    cal_nxt.day_in_year      = jan_feb ? 9'(doy11_r - 9'd306)
                                       : 9'(doy11_r + 9'd59 + 9'(leap11_r));
  end

  always_ff @(posedge clk) begin
    if (stage_ld[3]) begin
      z_r <= 24'(days_i + EPOCH_SHIFT);
    end
    if (stage_ld[4]) begin
      era4_r <= era_prod[48:42];
      z4_r   <= z_r[17:0];
    end
    if (stage_ld[5]) begin
      doe5_r <= 18'(z4_r - 18'(18'(era4_r) * DAYS_PER_ERA));
      era5_r <= era4_r;
    end
    if (stage_ld[6]) begin
      a6_r   <= a_prod[35:29];
      b6_r   <= b_prod[36:34];
      c6_r   <= (doe5_r == LAST_DOE);
      doe6_r <= doe5_r;
      era6_r <= era5_r;
    end
    if (stage_ld[7]) begin
      t7_r   <= 18'(doe6_r - 18'(a6_r) + 18'(b6_r) - 18'(c6_r));
      doe7_r <= doe6_r;
      era7_r <= era6_r;
    end
    if (stage_ld[8]) begin
      yoe8_r <= yoe_prod[35:27];
      doe8_r <= doe7_r;
      era8_r <= era7_r;
    end
    if (stage_ld[9]) begin
      y100_9_r <= c100_prod[17:16];
      base9_r  <= 18'(18'(yoe8_r) * 18'd365 + 18'(yoe8_r[8:2]));
      yoe9_r   <= yoe8_r;
      doe9_r   <= doe8_r;
      era9_r   <= era8_r;
    end
    if (stage_ld[10]) begin
      doy10_r  <= 9'(doe9_r - base9_r + 18'(y100_9_r));
      leap10_r <= (yoe9_r[1:0] == 2'd0) && ((ymod100 != 9'd0) || (yoe9_r == 9'd0));
      yoe10_r  <= yoe9_r;
      era10_r  <= era9_r;
    end
    if (stage_ld[11]) begin
      mp11_r   <= mp_prod[22:19];
      doy11_r  <= doy10_r;
      leap11_r <= leap10_r;
      yoe11_r  <= yoe10_r;
      era11_r  <= era10_r;
    end
    if (stage_ld[12]) begin
      cal_r <= cal_nxt;
    end
  end

  assign cal_o = cal_r;

endmodule

`default_nettype wire

// ===== rtl/core/edc_checker.sv =====
// edc_checker: port-level assertions for the calendar converter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module edc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] years_since_1900,
  input logic [3:0]         month_index,
  input logic [4:0]         day_of_month,
  input logic [4:0]         hour_of_day,
  input logic [5:0]         minute_of_hour,
  input logic [5:0]         second_of_minute,
  input logic [2:0]         weekday,
  input logic [8:0]         day_in_year
);
  import edc_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [4:0] inflight_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 5'd0;
    end else begin
      inflight_r <= 5'(inflight_r + 5'(in_acc) - 5'(out_acc));
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({years_since_1900, month_index, day_of_month,
                                         hour_of_day, minute_of_hour, second_of_minute,
                                         weekday, day_in_year}))
    else $error("result payload changed while stalled");

  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> month_index <= 4'd11 && day_of_month != 5'd0 && hour_of_day <= 5'd23 &&
                  minute_of_hour <= 6'd59 && second_of_minute <= 6'd59 &&
                  weekday <= 3'd6 && day_in_year <= 9'd365)
    else $error("result field out of range");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 5'd0)
    else $error("result beat without an accepted input");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r == 5'd0 |-> in_ready && inflight_r <= 5'(NUM_STAGES))
    else $error("empty pipeline refuses input");

endmodule

bind epoch_seconds_to_calendar edc_checker u_edc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .years_since_1900 (out_ch.years_since_1900),
  .month_index      (out_ch.month_index),
  .day_of_month     (out_ch.day_of_month),
  .hour_of_day      (out_ch.hour_of_day),
  .minute_of_hour   (out_ch.minute_of_hour),
  .second_of_minute (out_ch.second_of_minute),
  .weekday          (out_ch.weekday),
  .day_in_year      (out_ch.day_in_year)
);

`default_nettype wire

// ===== test/calendar_checker.sv =====
// calendar_checker: watches both channels, predicts calendar fields and compares result beats
`timescale 1ns / 1ps

module calendar_checker (
  input  logic clk,
  input  logic rst_n,
  edc_in_if    in_mon,
  edc_out_if   out_mon,
  output int   fail_count,
  output int   dates_outstanding
);

  localparam longint SECS_PER_DAY = 86400;
  localparam longint DAYS_PER_ERA = 146097;
  localparam longint DAY_SHIFT    = 719468;   // 0000-03-01 to 1970-01-01
  localparam int     MAX_PRINTED  = 40;

  typedef struct packed {
    logic signed [39:0] seconds_in;
    logic signed [15:0] year_off;
    logic [3:0]         month;
    logic [4:0]         mday;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [2:0]         wday;
    logic [8:0]         yday;
  } civil_time_t;

  civil_time_t dates_due[$];
  int          mismatch_total = 0;

  assign fail_count = mismatch_total;

  function automatic longint floor_quot(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint floor_rem(input longint a, input longint b);
    longint r;
    r = a % b;
    if (r < 0) r += b;
    return r;
  endfunction

  // Day number of January 1; January belongs to the prior March-based year
  function automatic longint jan1_day_number(input longint yr);
    longint y, era, yoe;
    y   = yr - 1;
    era = floor_quot(y, 400);
    yoe = y - era * 400;
    return era * DAYS_PER_ERA + yoe * 365 + yoe / 4 - yoe / 100 + 306 - DAY_SHIFT;
  endfunction

  function automatic civil_time_t civil_from_seconds(input logic signed [39:0] raw);
    civil_time_t d;
    longint secs, days, sod, z, era, doe, yoe, doy, mp, mday, month, year;
    secs  = longint'(raw);
    days  = floor_quot(secs, SECS_PER_DAY);
    sod   = floor_rem(secs, SECS_PER_DAY);
    z     = days + DAY_SHIFT;
    era   = floor_quot(z, DAYS_PER_ERA);
    doe   = z - era * DAYS_PER_ERA;
    yoe   = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy   = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp    = (5 * doy + 2) / 153;
    mday  = doy - (153 * mp + 2) / 5 + 1;
    month = (mp < 10) ? mp + 3 : mp - 9;
    year  = yoe + era * 400 + ((month <= 2) ? 1 : 0);
    d.seconds_in = raw;
    d.year_off   = 16'(year - 1900);
    d.month      = 4'(month - 1);
    d.mday       = 5'(mday);
    d.hour       = 5'(sod / 3600);
    d.minute     = 6'((sod % 3600) / 60);
    d.second     = 6'(sod % 60);
    d.wday       = 3'(floor_rem(days + 4, 7));
    d.yday       = 9'(days - jan1_day_number(year));
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_total < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_total++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want,
                             input logic signed [39:0] secs);
    if (got != want)
      report_mismatch($sformatf("secs %0d %s got %0d want %0d", secs, name, got, want));
  endtask

  always @(posedge clk) begin
    civil_time_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        dates_due.push_back(civil_from_seconds(in_mon.epoch_seconds));
      if (out_mon.valid && out_mon.ready) begin
        if (dates_due.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = dates_due.pop_front();
          check_field("years_since_1900", longint'(out_mon.years_since_1900),
                      longint'(want.year_off), want.seconds_in);
          check_field("month_index", longint'(out_mon.month_index),
                      longint'(want.month), want.seconds_in);
          check_field("day_of_month", longint'(out_mon.day_of_month),
                      longint'(want.mday), want.seconds_in);
          check_field("hour_of_day", longint'(out_mon.hour_of_day),
                      longint'(want.hour), want.seconds_in);
          check_field("minute_of_hour", longint'(out_mon.minute_of_hour),
                      longint'(want.minute), want.seconds_in);
          check_field("second_of_minute", longint'(out_mon.second_of_minute),
                      longint'(want.second), want.seconds_in);
          check_field("weekday", longint'(out_mon.weekday),
                      longint'(want.wday), want.seconds_in);
          check_field("day_in_year", longint'(out_mon.day_in_year),
                      longint'(want.yday), want.seconds_in);
        end
      end
    end
    dates_outstanding <= dates_due.size();
  end

endmodule

// ===== test/epoch_seconds_to_calendar_tb.sv =====
// epoch_seconds_to_calendar_tb: stimulus, flow control and verdict for the calendar converter
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_tb;

  import edc_pkg::*;

  // Generous bound: ~1370 beats under heavy idling, plus reset and drain,
  // taken many times over.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BEATS = 450;      // per idling phase, three phases

  // Hand-picked timestamps: epoch neighbors, floor split on negatives, field
  // extremes, leap days, century rules, the era origin and alternating bits.
  localparam int     NUM_DIRECTED = 22;
  localparam longint DIRECTED_SECS [NUM_DIRECTED] = '{
    0,                  // 1970-01-01 00:00:00, a Thursday
    -1,                 // 1969-12-31 23:59:59, floor split
    1,
    86399,              // last second of the first day
    86400,
    -86400,
    -86401,
    64'sd549755813887,  // largest input, far future
    -64'sd549755813888, // smallest input, far past
    951782400,          // 2000-02-29, leap day of a 400-year century
    951868800,          // 2000-03-01
    978307199,          // 2000-12-31 23:59:59, day of year 365
    946684799,          // 1999-12-31 23:59:59, day of year 364
    -64'sd2203891201,   // 1900-02-28 23:59:59, century without leap day
    -64'sd2203891200,   // 1900-03-01
    64'sd4107542400,    // 2100-03-01
    -64'sd62162035200,  // 0000-03-01, start of an era
    -64'sd62162035201,  // last second of the previous era
    -64'sd11670998400,  // 1600-02-29
    64'sd2147483648,    // just past the 32-bit rollover
    64'sd366503875925,  // 0x55_5555_5555
    -64'sd366503875926  // 0xAA_AAAA_AAAA
  };

  logic clk;
  logic rst_n;

  int src_idle_pct;      // chance per cycle that the sender holds off
  int snk_idle_pct;      // chance per cycle that the receiver stalls
  int cycle_count;
  int fail_count;
  int dates_outstanding;

  edc_in_if  in_ch ();
  edc_out_if out_ch ();

  epoch_seconds_to_calendar i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  calendar_checker i_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mon            (in_ch),
    .out_mon           (out_ch),
    .fail_count        (fail_count),
    .dates_outstanding (dates_outstanding)
  );

  // 12 ns period
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Known values on every block input from time zero
  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.epoch_seconds = '0;
    out_ch.ready        = 1'b0;
    src_idle_pct        = 19;
    snk_idle_pct        = 81;
    cycle_count         = 0;
  end

  // Receiver: random stalls, one decision per cycle, reset included
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Watchdog: a hung pipeline or a lost result ends up here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one beat and hold it until the block takes it. Idle cycles in
  // front of it carry junk payload with valid low. Returns right at the
  // accepting edge, so the next call drives valid once more in that step.
  task automatic send_seconds(input longint secs);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid         <= 1'b0;
      in_ch.epoch_seconds <= 40'({$urandom(), $urandom()});
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.epoch_seconds <= 40'(secs);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Random timestamp, mixed so that date edges get hit often:
  //   any 40-bit pattern, the 32-bit era around today, midnight edges on
  //   random days, and the turn of random years (Jan 1 and the end of Feb).
  function automatic longint pick_seconds();
    logic signed [39:0] any_bits;
    longint             days;
    longint             sod;
    longint             yr;
    int unsigned        kind;
    kind = $urandom_range(99);
    case ($urandom_range(3))
      0:       sod = 0;
      1:       sod = 86399;
      2:       sod = longint'($urandom_range(2)) + 86397;
      default: sod = longint'($urandom_range(86399));
    endcase
    if (kind < 30) begin
      any_bits = 40'({$urandom(), $urandom()});
      return longint'(any_bits);
    end else if (kind < 55) begin
      return longint'(int'($urandom()));
    end else if (kind < 75) begin
      // Whole input range is about +/- 6.36 million days
      days = longint'($urandom_range(12600000)) - 6300000;
      return days * 86400 + sod;
    end else begin
      // Rough start of a year, then a few days either side of it or of Mar 1
      yr   = longint'($urandom_range(34700)) - 15400;
      days = ((yr - 1970) * 146097) / 400 + longint'($urandom_range(6)) - 3;
      if ($urandom_range(1) == 1) days += 59;
      return days * 86400 + sod;
    end
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under the first idling mix
    for (int i = 0; i < NUM_DIRECTED; i++) send_seconds(DIRECTED_SECS[i]);

    // Busy sender against heavy backpressure first
    for (int i = 0; i < RANDOM_BEATS; i++) send_seconds(pick_seconds());

    // Swapped: sender idles often now, receiver rarely stalls
    src_idle_pct <= 81;
    snk_idle_pct <= 19;
    for (int i = 0; i < RANDOM_BEATS; i++) send_seconds(pick_seconds());

    // Full rate on both sides
    src_idle_pct <= 0;
    snk_idle_pct <= 0;
    for (int i = 0; i < RANDOM_BEATS; i++) send_seconds(pick_seconds());

    in_ch.valid <= 1'b0;

    // The count is registered, so step before looking at it
    do @(posedge clk); while (dates_outstanding != 0);
    // Give a stray extra result time to show up
    repeat (NUM_STAGES + 4) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
